>>> src/tia_pkg.sv
// Shared types and constants for the typed ID allocator.
package tia_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W = 5;
	localparam int REQ_W = 20;

	typedef enum logic [2:0] {
		CMD_ALLOC   = 3'd0,
		CMD_CLAIM   = 3'd1,
		CMD_FORCE   = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_PROBE   = 3'd4
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_RANGE        = 3'd1,
		ST_IN_USE       = 3'd2,
		ST_NOT_AVAIL    = 3'd3,
		ST_ALREADY_FREE = 3'd4,
		ST_NOT_IN_USE   = 3'd5,
		ST_EXHAUSTED    = 3'd6
	} status_e_t;

	typedef enum logic [1:0] {
		NX_OUT,
		NX_WR,
		NX_UP
	} next_e_t;

	typedef enum logic [3:0] {
		FS_CLR,
		FS_IDLE,
		FS_RD,
		FS_EV,
		FS_URD,
		FS_UEV,
		FS_WR,
		FS_DRD,
		FS_DEV,
		FS_OUT
	} fsm_e_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  obj_type;
		logic [19:0] instance_id;
		logic        force_check;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  granted_id;
		logic [22:0] combined_id;
		logic        can_generate;
	} result_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_tgt;
		logic eval;
		logic up_rd;
		logic up_eval;
		logic wr;
		logic dn_rd;
		logic dn_eval;
	} ctl_t;

	typedef struct packed {
		logic    clr_last;
		next_e_t ev_nx;
		logic    up_found;
		logic    up_last;
		logic    need_dn;
		logic    dn_done;
	} dp_stat_t;

endpackage

>>> src/tia_ram.sv
// Generic single-port-write, registered-read RAM.
module tia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/tia_ctrl.sv
// Sequencer for the typed ID allocator.
module tia_ctrl import tia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t st,
	output ctl_t     ctl,
	output logic     busy,
	output logic     done
);
	fsm_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			FS_CLR: begin
				ctl.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = FS_IDLE;
				end
			end
			FS_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d = FS_RD;
				end
			end
			FS_RD: begin
				ctl.rd_tgt = 1'b1;
				state_d = FS_EV;
			end
			FS_EV: begin
				ctl.eval = 1'b1;
				case (st.ev_nx)
					NX_WR: state_d = FS_WR;
					NX_UP: state_d = FS_URD;
					default: state_d = FS_OUT;
				endcase
			end
			FS_URD: begin
				ctl.up_rd = 1'b1;
				state_d = FS_UEV;
			end
			FS_UEV: begin
				ctl.up_eval = 1'b1;
				if (st.up_found) begin
					state_d = FS_WR;
				end else if (st.up_last) begin
					state_d = FS_OUT;
				end else begin
					state_d = FS_URD;
				end
			end
			FS_WR: begin
				ctl.wr = 1'b1;
				state_d = st.need_dn ? FS_DRD : FS_OUT;
			end
			FS_DRD: begin
				ctl.dn_rd = 1'b1;
				state_d = FS_DEV;
			end
			FS_DEV: begin
				ctl.dn_eval = 1'b1;
				state_d = st.dn_done ? FS_OUT : FS_DRD;
			end
			FS_OUT: begin
				done = 1'b1;
				state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end
endmodule

>>> src/tia_dp.sv
// Datapath: pool bitmap RAM, per-type trackers, word scanners.
module tia_dp import tia_pkg::*; #(
	parameter int NUM_TYPES = 8,
	parameter int ID_MAX = 1023
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_t     ctl,
	input  item_t    item,
	input  logic     cfg_we,
	input  logic [7:0] cfg_wdata,
	output dp_stat_t st,
	output result_t  result
);
	localparam int IW = $clog2(ID_MAX + 1);
	localparam int CW = $clog2(ID_MAX + 2);
	localparam int NW = (ID_MAX + 1 + WORD_W - 1) / WORD_W;
	localparam int WW = NW > 1 ? $clog2(NW) : 1;
	localparam int TW = NUM_TYPES > 1 ? $clog2(NUM_TYPES) : 1;
	localparam int AW = TW + WW;
	localparam int DEPTH = 1 << AW;
	localparam int TAIL = (ID_MAX + 1) % WORD_W;
	localparam logic [WW-1:0] LAST_WORD = WW'(NW - 1);
	localparam logic [WORD_W-1:0] LAST_MASK =
		(TAIL == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TAIL) - WORD_W'(1));

	// latched beat
	logic [2:0]        cmd_q;
	logic [2:0]        type_q;
	logic [REQ_W-1:0]  req_q;
	logic              force_q;
	logic [7:0]        asc_q;

	// per-type trackers
	logic              zf_q   [NUM_TYPES];
	logic              u0_q   [NUM_TYPES];
	logic              any_q  [NUM_TYPES];
	logic [IW-1:0]     hu_q   [NUM_TYPES];
	logic [CW-1:0]     ucnt_q [NUM_TYPES];

	logic [WW-1:0]     word_q;
	logic [AW-1:0]     clr_q;
	logic [IW-1:0]     tgt_q;
	logic              set_q;
	status_e_t         status_q;

	logic [TW-1:0]     tidx;
	logic              type_ok, zf, u0, any_u, asc, full, fc_zero, in_range;
	logic [IW-1:0]     hu;
	logic [CW-1:0]     ucnt;
	logic [IW:0]       start_id;
	logic              start_ok;
	logic [REQ_W-1:0]  tgt20;
	logic [BIT_W-1:0]  tbit;
	logic [WW-1:0]     tword;
	logic [WORD_W-1:0] rdata, onehot, vmask, up_m, dn_m;
	logic              used_bit, tgt0, tfree;
	status_e_t         ev_status;
	next_e_t           ev_nx;
	logic              ev_set;
	logic [BIT_W-1:0]  up_pos, dn_pos;
	logic              up_found, dn_found;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata;

	assign tidx = type_q[TW-1:0];
	assign type_ok = {29'd0, type_q} < NUM_TYPES;
	assign zf = zf_q[tidx];
	assign u0 = u0_q[tidx];
	assign any_u = any_q[tidx];
	assign hu = hu_q[tidx];
	assign ucnt = ucnt_q[tidx];
	assign asc = asc_q[type_q];
	assign full = ucnt >= CW'(ID_MAX);
	assign fc_zero = ((ucnt - CW'(u0)) == CW'(ID_MAX)) && !zf;
	assign in_range = req_q <= REQ_W'(ID_MAX);
	assign start_id = any_u ? ({1'b0, hu} + (IW+1)'(1)) : (IW+1)'(1);
	assign start_ok = start_id <= (IW+1)'(ID_MAX);

	assign tgt20 = REQ_W'(tgt_q);
	assign tbit = tgt20[BIT_W-1:0];
	assign tword = WW'(tgt20 >> BIT_W);
	assign onehot = WORD_W'(1) << tbit;
	assign used_bit = rdata[tbit];
	assign tgt0 = tgt_q == '0;
	assign tfree = tgt0 ? zf : !used_bit;
	assign vmask = (word_q == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};

	// id 0 only counts as free once it was released
	assign up_m = rdata | ~vmask | ((word_q == '0 && !zf) ? WORD_W'(1) : '0);
	assign dn_m = rdata & vmask;

	always_comb begin
		up_pos = '0;
		dn_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!up_m[i]) up_pos = BIT_W'(i);
		end
		for (int i = 0; i < WORD_W; i++) begin
			if (dn_m[i]) dn_pos = BIT_W'(i);
		end
	end
	assign up_found = ~&up_m;
	assign dn_found = |dn_m;

	always_comb begin
		ev_status = ST_NOT_AVAIL;
		ev_nx = NX_OUT;
		ev_set = 1'b1;
		if (type_ok) begin
			case (cmd_q)
				CMD_ALLOC: begin
					if (!asc) begin
						ev_status = ST_EXHAUSTED;
						ev_nx = NX_UP;
					end else if (fc_zero || !start_ok) begin
						ev_status = ST_EXHAUSTED;
					end else begin
						ev_status = ST_OK;
						ev_nx = NX_WR;
					end
				end
				CMD_CLAIM: begin
					if (!in_range) ev_status = ST_RANGE;
					else if (used_bit) ev_status = ST_IN_USE;
					else if (!tfree) ev_status = ST_NOT_AVAIL;
					else begin
						ev_status = ST_OK;
						ev_nx = NX_WR;
					end
				end
				CMD_FORCE: begin
					if (!in_range) ev_status = ST_RANGE;
					else begin
						ev_status = ST_OK;
						ev_nx = NX_WR;
					end
				end
				CMD_RELEASE: begin
					ev_set = 1'b0;
					if (!in_range) ev_status = ST_RANGE;
					else if ((tgt0 && zf) || (!tgt0 && !used_bit))
						ev_status = ST_ALREADY_FREE;
					else if (!used_bit) ev_status = ST_NOT_IN_USE;
					else begin
						ev_status = ST_OK;
						ev_nx = NX_WR;
					end
				end
				CMD_PROBE: begin
					if (full) ev_status = ST_EXHAUSTED;
					else if (!in_range) ev_status = ST_RANGE;
					else if (!force_q && used_bit) ev_status = ST_IN_USE;
					else if (!force_q && !tfree) ev_status = ST_NOT_AVAIL;
					else ev_status = ST_OK;
				end
				default: ev_status = ST_NOT_AVAIL;
			endcase
		end
	end

	assign st.clr_last = clr_q == {AW{1'b1}};
	assign st.ev_nx = ev_nx;
	assign st.up_found = up_found;
	assign st.up_last = word_q == LAST_WORD;
	assign st.need_dn = !set_q && (tgt_q == hu);
	assign st.dn_done = dn_found || (word_q == '0);

	// RAM ports
	always_comb begin
		ram_we = ctl.clr_step || ctl.wr;
		ram_waddr = ctl.clr_step ? clr_q : {tidx, tword};
		ram_wdata = ctl.clr_step ? '0 : (set_q ? (rdata | onehot) : (rdata & ~onehot));
		ram_re = ctl.rd_tgt || ctl.up_rd || ctl.dn_rd;
		if (ctl.rd_tgt) begin
			if (cmd_q == CMD_ALLOC && asc)
				ram_raddr = {tidx, WW'(REQ_W'(start_id) >> BIT_W)};
			else
				ram_raddr = {tidx, WW'(req_q >> BIT_W)};
		end else begin
			ram_raddr = {tidx, word_q};
		end
	end

	tia_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= item.command;
			type_q <= item.obj_type;
			req_q <= item.instance_id;
			force_q <= item.force_check;
			status_q <= ST_NOT_AVAIL;
		end
		if (ctl.rd_tgt) begin
			tgt_q <= (cmd_q == CMD_ALLOC && asc) ? start_id[IW-1:0] : req_q[IW-1:0];
		end
		if (ctl.eval) begin
			status_q <= ev_status;
			set_q <= ev_set;
		end
		if (ctl.up_eval && up_found) begin
			tgt_q <= IW'({word_q, up_pos});
			status_q <= ST_OK;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asc_q <= '0;
			clr_q <= '0;
			word_q <= '0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				zf_q[i] <= 1'b0;
				u0_q[i] <= 1'b0;
				any_q[i] <= 1'b0;
				hu_q[i] <= '0;
				ucnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) asc_q <= cfg_wdata;
			if (ctl.clr_step) clr_q <= clr_q + AW'(1);
			if (ctl.eval) word_q <= '0;
			if (ctl.up_eval && !up_found) word_q <= word_q + WW'(1);
			if (ctl.wr) begin
				if (set_q && !used_bit) begin
					ucnt_q[tidx] <= ucnt + CW'(1);
					if (tgt0) begin
						zf_q[tidx] <= 1'b0;
						u0_q[tidx] <= 1'b1;
					end
					if (!any_u || tgt_q > hu) begin
						hu_q[tidx] <= tgt_q;
						any_q[tidx] <= 1'b1;
					end
				end else if (!set_q) begin
					ucnt_q[tidx] <= ucnt - CW'(1);
					if (tgt0) begin
						zf_q[tidx] <= 1'b1;
						u0_q[tidx] <= 1'b0;
					end
					word_q <= LAST_WORD;
				end
			end
			if (ctl.dn_eval) begin
				if (dn_found) begin
					hu_q[tidx] <= IW'({word_q, dn_pos});
					any_q[tidx] <= 1'b1;
				end else if (word_q == '0) begin
					hu_q[tidx] <= '0;
					any_q[tidx] <= 1'b0;
				end else begin
					word_q <= word_q - WW'(1);
				end
			end
		end
	end

	assign result.status = status_q;
	assign result.granted_id = (status_q == ST_OK) ? tgt20[9:0] : '0;
	assign result.combined_id = (status_q == ST_OK) ? {type_q, tgt20} : '0;
	assign result.can_generate = type_ok && !full &&
		!(asc && any_u && hu == IW'(ID_MAX));
endmodule

>>> src/typed_id_allocator.sv
// Top level of the typed ID allocator.
//
//  channel   ports                  beat taken when
//  -------   --------------------   -------------------------
//  command   start, busy, item      start high and busy low
//  result    done, result           done high (one cycle, no stall)
//  config    cfg_we, cfg_wdata      cfg_we high
//
// Probe, claim, force claim, failed commands and ascending allocate read
// the target word, evaluate it and write it back when needed. Lowest-free
// allocate scans the pool upward one 32-bit RAM word at a time, W words
// per pool (32 at the default size). Releasing the highest used ID adds a
// downward scan of up to W words to rebuild the tracker.
// After reset a clearing pass writes every bitmap word (256 words at the
// default size) with busy high; the mask register is writable throughout.
// The receiver cannot stall: done is high for one cycle.
module typed_id_allocator import tia_pkg::*; #(
	parameter int NUM_TYPES = 8,
	parameter int ID_MAX = 1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	ctl_t     ctl;
	dp_stat_t st;

	// sequencer: one state per RAM access / evaluation step
	tia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// bitmap RAM, per-type trackers and the word scanners
	tia_dp #(.NUM_TYPES(NUM_TYPES), .ID_MAX(ID_MAX)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.st        (st),
		.result    (result)
	);
endmodule
